// ===== sv/quad_rotor_force_torque_step_unit_assert.svh =====
// Assertion macros for the rotor force and torque step unit.
// No dependencies; included by the files that carry concurrent checks.
`ifndef QUAD_ROTOR_FORCE_TORQUE_STEP_UNIT_ASSERT_SVH
`define QUAD_ROTOR_FORCE_TORQUE_STEP_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define QRFT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define QRFT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QRFT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define QRFT_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/qrft_pkg.sv =====
// Shared constants, register indexes and helper functions for the rotor
// force and torque step unit. No dependencies.
package qrft_pkg;

  localparam int NUM_MOTORS = 4;
  localparam int MOTOR_IDX_W = $clog2(NUM_MOTORS);

  localparam int CMD_W = 18;
  localparam int SPEED_W = 17;
  localparam int RATE_W = 32;
  localparam int COEF_W = 32;
  localparam int ALPHA_W = 17;
  localparam int OUT_W = 48;

  localparam int IN_DATA_W = 168;
  localparam int OUT_DATA_W = 192;

  localparam logic [SPEED_W-1:0] ONE_Q16 = 17'd65536;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAG_ALPHA = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_THRUST = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FULL_REACTION = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ARM_OFFSET = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOMENTUM_SCALE = 3'd4;

  localparam logic [ALPHA_W-1:0] RST_LAG_ALPHA = 17'd0;
  localparam logic [COEF_W-1:0] RST_MAX_THRUST = 32'd65536;
  localparam logic [COEF_W-1:0] RST_FULL_REACTION = 32'd1311;
  localparam logic [COEF_W-1:0] RST_ARM_OFFSET = 32'd0;
  localparam logic [COEF_W-1:0] RST_MOMENTUM_SCALE = 32'd0;

  // Sign of each motor's contribution; a set bit means the term is added.
  localparam logic [NUM_MOTORS-1:0] YAW_POS = 4'b0011;
  localparam logic [NUM_MOTORS-1:0] ROLL_POS = 4'b0110;
  localparam logic [NUM_MOTORS-1:0] PITCH_POS = 4'b0101;

  // Clamp a signed Q1.16 command to 0..1.
  function automatic logic [SPEED_W-1:0] clamp_cmd(input logic [CMD_W-1:0] raw);
    logic [SPEED_W-1:0] res;
    if (raw[CMD_W-1]) begin
      res = '0;
    end else if (raw[SPEED_W-1] && (|raw[SPEED_W-2:0])) begin
      res = ONE_Q16;
    end else begin
      res = raw[SPEED_W-1:0];
    end
    return res;
  endfunction

  // Saturate a 52 bit signed sum to the 48 bit output range.
  function automatic logic [OUT_W-1:0] sat_out(input logic signed [51:0] v);
    logic [OUT_W-1:0] res;
    if ((v[51:OUT_W-1] == '0) || (v[51:OUT_W-1] == '1)) begin
      res = v[OUT_W-1:0];
    end else if (v[51]) begin
      res = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ===== sv/quad_rotor_force_torque_step_unit.sv =====
// Top level of the rotor force and torque step unit: motor lag, X-frame mix
// and gyroscopic moment on one shared multiplier. Depends on qrft_pkg and
// quad_rotor_force_torque_step_unit_assert.svh.
//
//   Channel  Direction  Handshake                    Payload
//   s_axis   in         s_axis_tvalid/tready         four commands, three body rates
//   m_axis   out        m_axis_tvalid/tready         force_down and three torques
//   cfg      in         cfg_we (no ready)            cfg_index, cfg_data
//
// Requests are accepted only in idle, where ready is high. Each request runs
// three products for each of the four motors, five for the gyroscopic and arm
// products, a state to fold in the last of them, a state to write the output
// register and the return to idle. The pace is set by the single 34 by 32 bit
// multiplier, which does one product a cycle.
// A stalled result sits in the output register while the next request runs;
// the unit waits only if that result is still there when the next one is done.
// Reset is synchronous, clears the speeds and loads the register defaults.
module quad_rotor_force_torque_step_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // command_front_right, command_rear_left, command_front_left,
  // command_rear_right, rate_roll, rate_pitch, rate_yaw (from bit 0 up)
  input  logic [qrft_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // force_down, torque_roll, torque_pitch, torque_yaw (from bit 0 up)
  output logic [qrft_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                 cfg_we,
  input  logic [qrft_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [qrft_pkg::COEF_W-1:0]          cfg_data
);

`include "quad_rotor_force_torque_step_unit_assert.svh"

  // Each working state issues one product; the following cycle folds it in.
  typedef enum logic [3:0] {
    S_IDLE, S_LAG, S_REA, S_THR, S_SPIN, S_RARM, S_GQ, S_PARM, S_GP,
    S_FINISH, S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [qrft_pkg::ALPHA_W-1:0] lag_alpha;
  logic [qrft_pkg::COEF_W-1:0]  max_thrust;
  logic [qrft_pkg::COEF_W-1:0]  full_reaction;
  logic [qrft_pkg::COEF_W-1:0]  arm_offset;
  logic [qrft_pkg::COEF_W-1:0]  momentum_scale;

  // Motor state and the captured request.
  logic [qrft_pkg::SPEED_W-1:0] speed [qrft_pkg::NUM_MOTORS];
  logic [qrft_pkg::SPEED_W-1:0] cmd [qrft_pkg::NUM_MOTORS];
  logic [qrft_pkg::RATE_W-1:0]  rate_roll;
  logic [qrft_pkg::RATE_W-1:0]  rate_pitch;
  logic [qrft_pkg::MOTOR_IDX_W-1:0] motor;

  // Accumulators. The per-motor sums stay below 2^34 in magnitude, the final
  // roll and pitch sums below 2^51.
  logic signed [34:0] thrust_sum;
  logic signed [34:0] roll_sum;
  logic signed [34:0] pitch_sum;
  logic signed [34:0] yaw_sum;
  logic signed [34:0] h_mom;
  logic signed [51:0] roll_acc;
  logic signed [51:0] pitch_acc;

  // Shared multiplier: operands, and the registered product waiting to be used.
  logic signed [34:0] x_op;
  logic signed [32:0] y_op;
  logic [34:0] x_abs;
  logic [32:0] y_abs;
  logic [65:0] prod_full;
  logic [49:0] prod_mag;
  logic        prod_neg;
  logic        pend_valid;
  state_t      pend_op;
  logic [qrft_pkg::MOTOR_IDX_W-1:0] pend_motor;
  logic signed [50:0] prod_s;
  logic signed [51:0] prod52;
  logic signed [34:0] prod35;

  logic [qrft_pkg::ALPHA_W-1:0] alpha_eff;
  logic signed [18:0] lag_diff;
  logic signed [18:0] spin;
  logic signed [18:0] speed_sum;
  logic [qrft_pkg::SPEED_W-1:0] speed_next;
  logic issue;
  logic in_accept;
  logic out_load;

  assign s_axis_tready = (state == S_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // Alpha above one acts as one.
  assign alpha_eff = (lag_alpha > qrft_pkg::ONE_Q16) ? qrft_pkg::ONE_Q16 : lag_alpha;

  assign lag_diff = $signed({2'b00, cmd[motor]}) - $signed({2'b00, speed[motor]});
  assign spin = $signed({2'b00, speed[0]}) + $signed({2'b00, speed[1]})
              - $signed({2'b00, speed[2]}) - $signed({2'b00, speed[3]});

  // Operand selection for the product issued in this cycle.
  always_comb begin
    issue = 1'b1;
    x_op = '0;
    y_op = '0;
    case (state)
      S_LAG: begin
        x_op = {{16{lag_diff[18]}}, lag_diff};
        y_op = {16'b0, alpha_eff};
      end
      S_REA: begin
        x_op = {18'b0, cmd[motor]};
        y_op = {1'b0, full_reaction};
      end
      S_THR: begin
        x_op = {18'b0, speed[motor]};
        y_op = {1'b0, max_thrust};
      end
      S_SPIN: begin
        x_op = {{16{spin[18]}}, spin};
        y_op = {1'b0, momentum_scale};
      end
      S_RARM: begin
        x_op = roll_sum;
        y_op = {1'b0, arm_offset};
      end
      S_GQ: begin
        x_op = h_mom;
        y_op = {rate_pitch[qrft_pkg::RATE_W-1], rate_pitch};
      end
      S_PARM: begin
        x_op = pitch_sum;
        y_op = {1'b0, arm_offset};
      end
      S_GP: begin
        x_op = h_mom;
        y_op = {rate_roll[qrft_pkg::RATE_W-1], rate_roll};
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  // Magnitudes are multiplied and the sign applied afterwards, so every
  // product is rounded toward zero.
  assign x_abs = x_op[34] ? 35'(-x_op) : 35'(x_op);
  assign y_abs = y_op[32] ? 33'(-y_op) : 33'(y_op);
  assign prod_full = 66'(x_abs[33:0]) * 66'(y_abs[31:0]);

  assign prod_s = prod_neg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
  assign prod52 = {prod_s[50], prod_s};
  assign prod35 = prod_s[34:0];

  // New motor speed from the lag product, kept within 0..1.
  assign speed_sum = $signed({2'b00, speed[motor]}) + prod_s[18:0];
  always_comb begin
    if (speed_sum[18]) begin
      speed_next = '0;
    end else if (speed_sum > $signed({2'b00, qrft_pkg::ONE_Q16})) begin
      speed_next = qrft_pkg::ONE_Q16;
    end else begin
      speed_next = speed_sum[qrft_pkg::SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      motor <= '0;
      pend_valid <= 1'b0;
      pend_op <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      lag_alpha <= qrft_pkg::RST_LAG_ALPHA;
      max_thrust <= qrft_pkg::RST_MAX_THRUST;
      full_reaction <= qrft_pkg::RST_FULL_REACTION;
      arm_offset <= qrft_pkg::RST_ARM_OFFSET;
      momentum_scale <= qrft_pkg::RST_MOMENTUM_SCALE;
      for (int i = 0; i < qrft_pkg::NUM_MOTORS; i++) begin
        speed[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          qrft_pkg::CFG_LAG_ALPHA:      lag_alpha <= cfg_data[qrft_pkg::ALPHA_W-1:0];
          qrft_pkg::CFG_MAX_THRUST:     max_thrust <= cfg_data;
          qrft_pkg::CFG_FULL_REACTION:  full_reaction <= cfg_data;
          qrft_pkg::CFG_ARM_OFFSET:     arm_offset <= cfg_data;
          qrft_pkg::CFG_MOMENTUM_SCALE: momentum_scale <= cfg_data;
          default: begin
          end
        endcase
      end

      // Multiplier result register and what it belongs to.
      prod_mag <= prod_full[65:16];
      prod_neg <= x_op[34] ^ y_op[32];
      pend_valid <= issue;
      pend_op <= state;
      pend_motor <= motor;

      // Fold in last cycle's product.
      if (pend_valid) begin
        case (pend_op)
          S_LAG: speed[motor] <= speed_next;
          S_REA: begin
            yaw_sum <= qrft_pkg::YAW_POS[pend_motor] ? yaw_sum + prod35 : yaw_sum - prod35;
          end
          S_THR: begin
            thrust_sum <= thrust_sum + prod35;
            roll_sum <= qrft_pkg::ROLL_POS[pend_motor] ? roll_sum + prod35
                                                       : roll_sum - prod35;
            pitch_sum <= qrft_pkg::PITCH_POS[pend_motor] ? pitch_sum + prod35
                                                         : pitch_sum - prod35;
          end
          S_SPIN: h_mom <= prod35;
          S_RARM: roll_acc <= prod52;
          S_GQ:   roll_acc <= roll_acc - prod52;
          S_PARM: pitch_acc <= prod52;
          S_GP:   pitch_acc <= pitch_acc + prod52;
          default: begin
          end
        endcase
      end

      if (m_axis_tvalid && m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            for (int i = 0; i < qrft_pkg::NUM_MOTORS; i++) begin
              cmd[i] <= qrft_pkg::clamp_cmd(
                s_axis_tdata[i*qrft_pkg::CMD_W +: qrft_pkg::CMD_W]);
            end
            rate_roll <= s_axis_tdata[72 +: qrft_pkg::RATE_W];
            rate_pitch <= s_axis_tdata[104 +: qrft_pkg::RATE_W];
            thrust_sum <= '0;
            roll_sum <= '0;
            pitch_sum <= '0;
            yaw_sum <= '0;
            motor <= '0;
            state <= S_LAG;
          end
        end
        S_LAG: state <= S_REA;
        S_REA: state <= S_THR;
        S_THR: begin
          if (motor == qrft_pkg::MOTOR_IDX_W'(qrft_pkg::NUM_MOTORS - 1)) begin
            state <= S_SPIN;
          end else begin
            motor <= motor + 1'b1;
            state <= S_LAG;
          end
        end
        S_SPIN:   state <= S_RARM;
        S_RARM:   state <= S_GQ;
        S_GQ:     state <= S_PARM;
        S_PARM:   state <= S_GP;
        S_GP:     state <= S_FINISH;
        S_FINISH: state <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            // Force and yaw cannot leave the output range; roll and pitch can.
            m_axis_tdata[47:0] <= qrft_pkg::sat_out(-{{17{thrust_sum[34]}}, thrust_sum});
            m_axis_tdata[95:48] <= qrft_pkg::sat_out(roll_acc);
            m_axis_tdata[143:96] <= qrft_pkg::sat_out(pitch_acc);
            m_axis_tdata[191:144] <= qrft_pkg::sat_out({{17{yaw_sum[34]}}, yaw_sum});
            m_axis_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A request always starts a fresh pass at the first motor with nothing
  // left in the multiplier.
  `QRFT_ASSERT_NXT(a_start, clk, rst, in_accept,
    (state == S_LAG) && (motor == '0) && !s_axis_tready,
    "request did not start at the first motor")
  `QRFT_ASSERT_IMP(a_idle_clean, clk, rst, s_axis_tready,
    !pend_valid || (pend_op == S_DONE) || (pend_op == S_IDLE) || (pend_op == S_FINISH),
    "ready with a product still pending")
  `QRFT_ASSERT_IMP(a_out_from_done, clk, rst, $rose(m_axis_tvalid), $past(state == S_DONE),
    "result shown without finishing a request")
  `QRFT_ASSERT_IMP(a_speed_range, clk, rst, 1'b1,
    (speed[0] <= qrft_pkg::ONE_Q16) && (speed[1] <= qrft_pkg::ONE_Q16)
      && (speed[2] <= qrft_pkg::ONE_Q16) && (speed[3] <= qrft_pkg::ONE_Q16),
    "motor speed above one")

endmodule
